### design/aarm_pkg.sv
// Package for the axis-angle to rotation matrix unit: widths, CORDIC constants,
// arctangent table and the stage payload types. No dependencies.
package aarm_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int CW            = 36;   // CORDIC word, Q30 with headroom
   localparam int CFG_W         = 30;
   localparam int LAT           = CORDIC_STAGES + 6;

   localparam logic signed [CW-1:0] PI_Q30      = 36'sd3373259426;
   localparam logic signed [CW-1:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [CW-1:0] CORDIC_X0   = 36'sd652032874;
   localparam logic [CFG_W-1:0]     CFG_RESET   = 30'd268;

   function automatic logic signed [CW-1:0] atan_q30(input int i);
      logic signed [CW-1:0] r;
      case (i)
         0: r = 36'sd843314857;   1: r = 36'sd497837829;
         2: r = 36'sd263043837;   3: r = 36'sd133525159;
         4: r = 36'sd67021687;    5: r = 36'sd33543516;
         6: r = 36'sd16775851;    7: r = 36'sd8388437;
         8: r = 36'sd4194283;     9: r = 36'sd2097149;
         default: r = CW'(64'sd1073741824 >>> i);
      endcase
      return r;
   endfunction

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic               degen;
   } axis_type;

endpackage

### design/axis_angle_to_rotation_matrix_unit.sv
// Axis-angle to rotation matrix unit: CORDIC cos/sin then Rodrigues matrix.
// Depends on aarm_pkg, aarm_cordic and aarm_matrix.
// Pipeline: quadrant fold, CORDIC stages, five matrix stages, then the output register.
// Throughput: one transfer per cycle while the skid is empty; the whole pipeline advances together.
// A skid register behind the output holds one transfer while rsp stalls; req_tready drops while it is full.
// Reset (synchronous, active high) clears all valid bits and the threshold to 268.
module axis_angle_to_rotation_matrix_unit import aarm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,   // axis_x, axis_y, axis_z, angle
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [143:0] rsp_tdata,   // m00 m01 m02 m10 m11 m12 m20 m21 m22
   output logic         rsp_tuser,   // degenerate
   input  logic         csr_we,
   input  logic [29:0]  csr_wdata
);
   logic [CFG_W-1:0] thr_ff;
   logic             en;
   logic             p_valid, p_degen;
   logic [143:0]     p_m;
   logic             c_valid;
   logic signed [CW-1:0] c_cos, c_sin;
   axis_type         ain, c_axis;
   logic             o_valid_ff, s_valid_ff;
   logic [144:0]     o_ff, s_ff;
   logic [33:0]      norm;

   always_ff @(posedge clock) begin
      if (reset) thr_ff <= CFG_RESET;
      else if (csr_we) thr_ff <= csr_wdata;
   end

   // advance the pipeline whenever the skid slot is free
   assign en         = !s_valid_ff;
   assign req_tready = en;

   always_comb begin
      ain.x = req_tdata[15:0];
      ain.y = req_tdata[31:16];
      ain.z = req_tdata[47:32];
      norm  = 34'(ain.x * ain.x) + 34'(ain.y * ain.y) + 34'(ain.z * ain.z);
      ain.degen = norm < {4'b0, thr_ff};
   end

   aarm_cordic u_cordic (
      .clock, .reset, .en,
      .in_valid (req_tvalid),
      .in_angle (req_tdata[63:48]),
      .in_axis  (ain),
      .out_valid(c_valid), .out_cos(c_cos), .out_sin(c_sin), .out_axis(c_axis)
   );

   aarm_matrix u_matrix (
      .clock, .reset, .en,
      .in_valid(c_valid), .in_cos(c_cos), .in_sin(c_sin), .in_axis(c_axis),
      .out_valid(p_valid), .out_m(p_m), .out_degen(p_degen)
   );

   // output register plus skid: hold a transfer in the skid while rsp stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
         s_valid_ff <= 1'b0;
      end else begin
         if (!o_valid_ff || rsp_tready) begin
            if (s_valid_ff) begin
               o_valid_ff <= 1'b1; s_valid_ff <= 1'b0;
            end else begin
               o_valid_ff <= p_valid;
            end
         end else if (p_valid && en) begin
            s_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!o_valid_ff || rsp_tready) begin
         o_ff <= s_valid_ff ? s_ff : {p_degen, p_m};
      end else if (p_valid && en) begin
         s_ff <= {p_degen, p_m};
      end
   end

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tdata  = o_ff[143:0];
   assign rsp_tuser  = o_ff[144];
endmodule

### design/aarm_cordic.sv
// Pipelined rotation-mode CORDIC with quadrant fold; carries the axis alongside.
// Depends on aarm_pkg.
module aarm_cordic import aarm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic signed [15:0]   in_angle,
   input  axis_type             in_axis,
   output logic                 out_valid,
   output logic signed [CW-1:0] out_cos,
   output logic signed [CW-1:0] out_sin,
   output axis_type             out_axis
);
   logic                 v_ff [CORDIC_STAGES+1];
   logic signed [CW-1:0] x_ff [CORDIC_STAGES+1];
   logic signed [CW-1:0] y_ff [CORDIC_STAGES+1];
   logic signed [CW-1:0] z_ff [CORDIC_STAGES+1];
   logic                 n_ff [CORDIC_STAGES+1];
   axis_type             a_ff [CORDIC_STAGES+1];
   logic signed [CW-1:0] z_in;

   always_comb begin
      z_in = CW'(in_angle) <<< 17;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= CORDIC_STAGES; i++) v_ff[i] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int i = 0; i < CORDIC_STAGES; i++) v_ff[i+1] <= v_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0] <= CORDIC_X0;
         y_ff[0] <= '0;
         a_ff[0] <= in_axis;
         if (z_in > HALF_PI_Q30) begin
            z_ff[0] <= z_in - PI_Q30; n_ff[0] <= 1'b1;
         end else if (z_in < -HALF_PI_Q30) begin
            z_ff[0] <= z_in + PI_Q30; n_ff[0] <= 1'b1;
         end else begin
            z_ff[0] <= z_in; n_ff[0] <= 1'b0;
         end
         for (int i = 0; i < CORDIC_STAGES; i++) begin
            a_ff[i+1] <= a_ff[i];
            n_ff[i+1] <= n_ff[i];
            if (!z_ff[i][CW-1]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_q30(i);
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_q30(i);
            end
         end
      end
   end

   assign out_valid = v_ff[CORDIC_STAGES];
   assign out_cos   = n_ff[CORDIC_STAGES] ? -x_ff[CORDIC_STAGES] : x_ff[CORDIC_STAGES];
   assign out_sin   = n_ff[CORDIC_STAGES] ? -y_ff[CORDIC_STAGES] : y_ff[CORDIC_STAGES];
   assign out_axis  = a_ff[CORDIC_STAGES];
endmodule

### design/aarm_matrix.sv
// Rodrigues matrix pipeline: products, sums, rounding and saturation.
// Depends on aarm_pkg.
module aarm_matrix import aarm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic signed [CW-1:0] in_cos,
   input  logic signed [CW-1:0] in_sin,
   input  axis_type             in_axis,
   output logic                 out_valid,
   output logic [143:0]         out_m,
   output logic                 out_degen
);
   logic [4:0] v_ff;
   // stage 1: c, s, t in Q20
   logic signed [22:0] c1_ff, s1_ff, t1_ff;
   axis_type           a1_ff, a2_ff, a3_ff, a4_ff;
   // stage 2: axis products Q28 and scaled sine terms
   logic signed [32:0] p_ff [6];   // xx yy zz xy xz yz
   logic signed [39:0] q_ff [3];   // x s, y s, z s (Q34)
   logic signed [22:0] c2_ff, t2_ff;
   // stage 3: times t, Q48
   logic signed [57:0] pt_ff [6];
   logic signed [57:0] qs_ff [3];
   logic signed [57:0] cq_ff;
   // stage 4: sums
   logic signed [59:0] e_ff [9];
   logic [15:0]        m_ff [9];
   logic signed [22:0] c1_in, s1_in;

   always_comb begin
      c1_in = 23'((in_cos + 36'sd512) >>> 10);
      s1_in = 23'((in_sin + 36'sd512) >>> 10);
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (en) v_ff <= {v_ff[3:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c1_ff <= c1_in; s1_ff <= s1_in;
         t1_ff <= 23'sd1048576 - c1_in;
         a1_ff <= in_axis;

         p_ff[0] <= 33'(a1_ff.x * a1_ff.x);
         p_ff[1] <= 33'(a1_ff.y * a1_ff.y);
         p_ff[2] <= 33'(a1_ff.z * a1_ff.z);
         p_ff[3] <= 33'(a1_ff.x * a1_ff.y);
         p_ff[4] <= 33'(a1_ff.x * a1_ff.z);
         p_ff[5] <= 33'(a1_ff.y * a1_ff.z);
         q_ff[0] <= 40'(a1_ff.x * s1_ff);
         q_ff[1] <= 40'(a1_ff.y * s1_ff);
         q_ff[2] <= 40'(a1_ff.z * s1_ff);
         c2_ff <= c1_ff; t2_ff <= t1_ff; a2_ff <= a1_ff;

         for (int i = 0; i < 6; i++) pt_ff[i] <= 58'(p_ff[i] * t2_ff);
         for (int i = 0; i < 3; i++) qs_ff[i] <= 58'(q_ff[i]) <<< 14;
         cq_ff <= 58'(c2_ff) <<< 28;
         a3_ff <= a2_ff;

         e_ff[0] <= 60'(cq_ff) + 60'(pt_ff[0]);
         e_ff[1] <= 60'(pt_ff[3]) - 60'(qs_ff[2]);
         e_ff[2] <= 60'(pt_ff[4]) + 60'(qs_ff[1]);
         e_ff[3] <= 60'(pt_ff[3]) + 60'(qs_ff[2]);
         e_ff[4] <= 60'(cq_ff) + 60'(pt_ff[1]);
         e_ff[5] <= 60'(pt_ff[5]) - 60'(qs_ff[0]);
         e_ff[6] <= 60'(pt_ff[4]) - 60'(qs_ff[1]);
         e_ff[7] <= 60'(pt_ff[5]) + 60'(qs_ff[0]);
         e_ff[8] <= 60'(cq_ff) + 60'(pt_ff[2]);
         a4_ff <= a3_ff;

         for (int i = 0; i < 9; i++) begin
            logic signed [59:0] r;
            r = (e_ff[i] + 60'sd8589934592) >>> 34;
            if (a4_ff.degen)          m_ff[i] <= '0;
            else if (r > 60'sd32767)  m_ff[i] <= 16'h7FFF;
            else if (r < -60'sd32768) m_ff[i] <= 16'h8000;
            else                      m_ff[i] <= r[15:0];
         end
         out_degen <= a4_ff.degen;
      end
   end

   assign out_valid = v_ff[4];
   always_comb begin
      for (int i = 0; i < 9; i++) out_m[16*i +: 16] = m_ff[i];
   end
endmodule

### bench/tb_axis_angle_to_rotation_matrix_unit.sv
// Self-checking bench for axis_angle_to_rotation_matrix_unit: a CORDIC and Rodrigues
// predictor checks every matrix transfer. Depends on aarm_pkg and the unit's RTL.
module tb_axis_angle_to_rotation_matrix_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import aarm_pkg::*;

   typedef struct packed {
      logic [143:0] mat;
      logic         degen;
   } rot_result_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [63:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [143:0] rsp_tdata;
   logic         rsp_tuser;
   logic         csr_we = 1'b0;
   logic [29:0]  csr_wdata = '0;

   logic [29:0]     norm_thresh;
   rot_result_type  pending_mats[$];
   int              n_fail = 0;
   int              n_sent = 0;
   int              n_degen = 0;
   int              n_got = 0;
   int              stall_mode = 0;

   axis_angle_to_rotation_matrix_unit DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // floor division by 2^s; >>> on a signed longint is already a floor shift
   function automatic longint fshift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic logic [15:0] sat_q14(longint v);
      longint r;
      r = fshift(v + (64'sd1 <<< 33), 34);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
   endfunction

   function automatic rot_result_type rodrigues(logic [63:0] d);
      rot_result_type res;
      longint x, y, z, ang, nrm, cx, cy, cz, dx, dy, c, s, t, cq, zs, ys, xs;
      logic flip;
      x = longint'($signed(d[15:0]));
      y = longint'($signed(d[31:16]));
      z = longint'($signed(d[47:32]));
      ang = longint'($signed(d[63:48])) * 131072;
      nrm = x * x + y * y + z * z;
      res = '0;
      if (nrm < longint'(norm_thresh)) begin
         res.degen = 1'b1;
         return res;
      end
      // fold the angle into plus or minus pi/2, negate the result after
      cx = longint'(CORDIC_X0); cy = 0; cz = ang; flip = 1'b0;
      if (cz > longint'(HALF_PI_Q30)) begin
         cz -= longint'(PI_Q30); flip = 1'b1;
      end else if (cz < -longint'(HALF_PI_Q30)) begin
         cz += longint'(PI_Q30); flip = 1'b1;
      end
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         dx = fshift(cy, i);
         dy = fshift(cx, i);
         if (cz >= 0) begin
            cx -= dx; cy += dy; cz -= longint'(atan_q30(i));
         end else begin
            cx += dx; cy -= dy; cz += longint'(atan_q30(i));
         end
      end
      if (flip) begin
         cx = -cx; cy = -cy;
      end
      c = fshift(cx + 512, 10);
      s = fshift(cy + 512, 10);
      t = (64'sd1 <<< 20) - c;
      cq = c * 268435456;
      zs = z * s * 16384; ys = y * s * 16384; xs = x * s * 16384;
      res.mat[15:0]    = sat_q14(cq + x * x * t);
      res.mat[31:16]   = sat_q14(x * y * t - zs);
      res.mat[47:32]   = sat_q14(x * z * t + ys);
      res.mat[63:48]   = sat_q14(x * y * t + zs);
      res.mat[79:64]   = sat_q14(cq + y * y * t);
      res.mat[95:80]   = sat_q14(y * z * t - xs);
      res.mat[111:96]  = sat_q14(x * z * t - ys);
      res.mat[127:112] = sat_q14(y * z * t + xs);
      res.mat[143:128] = sat_q14(cq + z * z * t);
      return res;
   endfunction

   // Receiver: stall on its own pattern, check each accepted transfer.
   always @(posedge clock) begin
      rot_result_type exp_r;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            n_got++;
            if (pending_mats.size() == 0) begin
               $error("unexpected transfer: tdata %h tuser %b", rsp_tdata, rsp_tuser);
               n_fail++;
            end else begin
               exp_r = pending_mats.pop_front();
               for (int k = 0; k < 9; k++)
                  if (rsp_tdata[16*k +: 16] !== exp_r.mat[16*k +: 16]) begin
                     $error("m%0d%0d: expected %h, got %h", k / 3, k % 3,
                            exp_r.mat[16*k +: 16], rsp_tdata[16*k +: 16]);
                     n_fail++;
                  end
               if (rsp_tuser !== exp_r.degen) begin
                  $error("degenerate: expected %b, got %b", exp_r.degen, rsp_tuser);
                  n_fail++;
               end
            end
         end
      end
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         default: rsp_tready <= ($urandom_range(0, 9) > 6);
      endcase
   end

   // Send one item; the expectation is queued at the accepting edge.
   task automatic send_item(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                            logic [15:0] an);
      req_tvalid <= 1'b1;
      req_tdata  <= {an, az, ay, ax};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_mats = {pending_mats, rodrigues({an, az, ay, ax})};
      n_sent++;
      if (norm_thresh != 0 && rodrigues({an, az, ay, ax}).degen) n_degen++;
   endtask

   task automatic idle_req(int n);
      req_tvalid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Wait for every expected transfer, let the pipeline drain, then write the new threshold.
   task automatic drain_and_write(logic [29:0] v);
      req_tvalid <= 1'b0;
      while (pending_mats.size() != 0) @(posedge clock);
      repeat (LAT + 4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      norm_thresh = v;
   endtask

   function automatic logic [15:0] rand_angle();
      return 16'($signed($urandom_range(0, 51472)) - 25736);
   endfunction

   task automatic test_directed();
      logic [15:0] edges[6] = '{16'h8000, 16'h7fff, 16'h0000, 16'h4000, 16'hc000, 16'hffff};
      stall_mode = 0;
      send_item(16'h4000, 16'h0000, 16'h0000, 16'd0);
      send_item(16'h0000, 16'h4000, 16'h0000, 16'd25736);     // +pi
      send_item(16'h0000, 16'h0000, 16'h4000, -16'sd25736);   // -pi
      send_item(16'h4000, 16'h0000, 16'h0000, 16'd12868);     // +pi/2
      send_item(16'h0000, 16'h4000, 16'h0000, -16'sd12868);
      send_item(16'h0000, 16'h0000, 16'h4000, 16'd12869);     // just past pi/2
      send_item(16'h8000, 16'h8000, 16'h8000, 16'd20000);     // saturating entries
      send_item(16'h7fff, 16'h7fff, 16'h7fff, -16'sd20000);
      send_item(16'h7fff, 16'h8000, 16'h7fff, 16'h7fff);      // beyond pi
      send_item(16'h8000, 16'h7fff, 16'h0000, 16'h8000);
      send_item(16'h0000, 16'h0000, 16'h0000, 16'd1000);      // zero axis
      send_item(16'h0010, 16'h0000, 16'h0000, 16'd1000);      // norm 256, under 268
      send_item(16'h0010, 16'h0002, 16'h0002, 16'd1000);      // norm 264
      send_item(16'h0010, 16'h0003, 16'h0000, 16'd1000);      // norm 265
      send_item(16'h0010, 16'h0003, 16'h0001, 16'd1000);      // norm 266
      send_item(16'h0010, 16'h0003, 16'h0002, 16'd1000);      // norm 269, just over
      for (int i = 0; i < 6; i++)
         send_item(edges[i], edges[5 - i], edges[(i + 2) % 6], edges[(i + 3) % 6]);
   endtask

   task automatic test_threshold_edges();
      drain_and_write(30'd269);
      send_item(16'h0010, 16'h0003, 16'h0002, 16'd500);       // exactly at threshold
      send_item(16'h0010, 16'h0002, 16'h0002, 16'd500);
      drain_and_write(30'd0);
      send_item(16'h0000, 16'h0000, 16'h0000, 16'd500);       // zero passes at threshold 0
      drain_and_write(30'h3fffffff);
      send_item(16'h8000, 16'h8000, 16'h8000, 16'd500);       // largest norm, above the top
      send_item(16'h7fff, 16'h0000, 16'h0000, 16'd500);       // just under the top
   endtask

   // Bursts with random gaps; a few axes are tiny to hit the threshold region.
   task automatic test_random(int count, int mode);
      int left;
      logic [15:0] ax, ay, az;
      stall_mode = mode;
      left = count;
      while (left > 0) begin
         for (int b = $urandom_range(1, 24); b > 0 && left > 0; b--) begin
            case ($urandom_range(0, 7))
               0: begin
                  ax = 16'($signed($urandom_range(0, 64)) - 32);
                  ay = 16'($signed($urandom_range(0, 64)) - 32);
                  az = 16'($signed($urandom_range(0, 64)) - 32);
               end
               1: begin
                  ax = 16'h4000; ay = 16'($urandom); az = 16'h0000;
               end
               default: begin
                  ax = 16'($urandom); ay = 16'($urandom); az = 16'($urandom);
               end
            endcase
            send_item(ax, ay, az, ($urandom_range(0, 9) == 0) ? 16'($urandom) : rand_angle());
            left--;
         end
         if ($urandom_range(0, 2) != 0) idle_req($urandom_range(1, 30));
      end
   endtask

   initial begin
      norm_thresh = CFG_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_threshold_edges();
      drain_and_write(CFG_RESET);
      test_random(350, 1);
      drain_and_write(30'd1000);
      test_random(300, 2);
      drain_and_write(30'd268435456);   // unit length squared
      test_random(250, 0);
      drain_and_write(30'd5);
      test_random(200, 1);
      req_tvalid <= 1'b0;
      while (pending_mats.size() != 0) @(posedge clock);
      repeat (LAT + 10) @(posedge clock);
      $display("Sent %0d transfers and checked %0d (%0d degenerate) over several thresholds,",
               n_sent, n_got, n_degen);
      $display("with random gaps on input and three output stall patterns.");
      if (n_fail == 0)
         $display("** axis_angle_to_rotation_matrix_unit: PASSED **");
      else
         $display("** axis_angle_to_rotation_matrix_unit: FAILED **");
      $finish;
   end

   initial begin
      #2ms;
      $display("timeout with %0d transfers outstanding", pending_mats.size());
      $display("** axis_angle_to_rotation_matrix_unit: FAILED **");
      $finish;
   end

endmodule
